FILE: hdl/bavg_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// bavg_pkg
// Shared types, widths and constants for the block average downsampler.
// ============================================================================
package bavg_pkg;

    localparam int MAX_BLOCK_COLS = 128;
    localparam int BCOL_W         = $clog2(MAX_BLOCK_COLS);
    localparam int SUM_W          = 20;
    localparam int POS_W          = 10;
    localparam int DIM_W          = 11;
    localparam int LG_W           = 3;
    localparam int BROW_W         = 9;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 11;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_REGION_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LOG2    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAINT_MODE    = 2'd3;

    localparam logic [DIM_W-1:0] DIM_MIN = 11'd1;
    localparam logic [DIM_W-1:0] DIM_MAX = 11'd1024;
    localparam logic [LG_W-1:0]  LG_MIN  = 3'd1;
    localparam logic [LG_W-1:0]  LG_MAX  = 3'd6;

    localparam logic [DIM_W-1:0] RST_WIDTH  = 11'd784;
    localparam logic [DIM_W-1:0] RST_HEIGHT = 11'd464;
    localparam logic [LG_W-1:0]  RST_LG     = 3'd4;

    // Division by three: q = (s * 683) >> 11 is exact for s up to 765.
    localparam logic [9:0] DIV3_RECIP = 10'd683;
    localparam int         DIV3_SHIFT = 11;

    localparam logic [7:0] COLOR_KEEP_MASK = 8'hF0;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } sums_t;

    localparam int SUMS_W = $bits(sums_t);

endpackage

FILE: hdl/bavg_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// bavg_ram
// Generic single write port, single read port RAM with a registered read.
// ============================================================================
module bavg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

FILE: hdl/block_average_downsample.sv
`timescale 1ns / 1ps
// ============================================================================
// block_average_downsample
// Box filter that averages RGB pixels over square blocks and emits one
// coarse color or gray level per finished block.
// ============================================================================
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-----------------------------------
//  pixel in | input     | in_valid / in_stall | pixel_rgb
//  block out| output    | out_valid/out_stall | block_col, block_row, avg_color,
//           |           |                     | gray_level
//  config   | input     | cfg_wen             | cfg_addr, cfg_wdata
//
// One pixel request is taken every clock while the output side keeps up.
// A finished block passes from the add and write-back stage to the gray-level
// stage and then into the output register.
// Reset clears a valid bit per block column, so the sum RAM needs no clearing
// pass. Output stalls back up through the pipeline; a stage holding a
// non-emitting pixel still retires.
//
module block_average_downsample
    import bavg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [23:0]            pixel_rgb,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [BCOL_W-1:0]      block_col,
    output logic [BROW_W-1:0]      block_row,
    output logic [23:0]            avg_color,
    output logic [3:0]             gray_level,

    input  logic                   cfg_wen,
    input  logic [CFG_IDX_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [LG_W-1:0]  lg_reg;
    logic             paint_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            lg_reg     <= RST_LG;
            paint_reg  <= 1'b0;
        end
        else if (cfg_wen)
        begin
            case (cfg_addr)
                REG_REGION_WIDTH:  width_reg  <= cfg_wdata[DIM_W-1:0];
                REG_REGION_HEIGHT: height_reg <= cfg_wdata[DIM_W-1:0];
                REG_BLOCK_LOG2:    lg_reg     <= cfg_wdata[LG_W-1:0];
                REG_PAINT_MODE:    paint_reg  <= cfg_wdata[0];
                default:           ;
            endcase
        end
    end

    // Saturated working values of the registers.
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [LG_W-1:0]  lg_eff;

    always_comb
    begin
        w_eff  = (width_reg < DIM_MIN) ? DIM_MIN :
                 (width_reg > DIM_MAX) ? DIM_MAX : width_reg;
        h_eff  = (height_reg < DIM_MIN) ? DIM_MIN :
                 (height_reg > DIM_MAX) ? DIM_MAX : height_reg;
        lg_eff = (lg_reg < LG_MIN) ? LG_MIN :
                 (lg_reg > LG_MAX) ? LG_MAX : lg_reg;
    end

    // ------------------------------------------------------------------
    // Stage 0: raster position, block decode and RAM read request.
    // ------------------------------------------------------------------
    logic [POS_W-1:0] col_reg;
    logic [POS_W-1:0] row_reg;
    logic [POS_W-1:0] col_next;
    logic [POS_W-1:0] row_next;

    logic [DIM_W-1:0] col_inc;
    logic [DIM_W-1:0] row_inc;
    logic [DIM_W-1:0] bmask;
    logic             row_end;
    logic             frame_end;
    logic [POS_W-1:0] bcol_full;
    logic [POS_W-1:0] brow_full;
    logic             in_range;
    logic             blk_done;
    logic             in_acc;
    logic             load_s1;

    always_comb
    begin
        col_inc   = {1'b0, col_reg} + 11'd1;
        row_inc   = {1'b0, row_reg} + 11'd1;
        bmask     = (DIM_W'(1) << lg_eff) - DIM_W'(1);
        row_end   = col_inc >= w_eff;
        frame_end = row_inc >= h_eff;
        bcol_full = col_reg >> lg_eff;
        brow_full = row_reg >> lg_eff;
        in_range  = bcol_full < POS_W'(MAX_BLOCK_COLS);
        blk_done  = (((col_inc & bmask) == '0) || row_end) &&
                    (((row_inc & bmask) == '0) || frame_end);

        col_next = col_reg;
        row_next = row_reg;
        if (in_acc)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = frame_end ? '0 : row_inc[POS_W-1:0];
            end
            else
            begin
                col_next = col_inc[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Sum memory, one entry per block column, plus a valid bit per entry.
    // An entry whose valid bit is clear reads as zero.
    // ------------------------------------------------------------------
    logic                  ram_we;
    logic [BCOL_W-1:0]     ram_waddr;
    sums_t                 ram_wdata;
    logic                  ram_re;
    logic [BCOL_W-1:0]     ram_raddr;
    sums_t                 ram_rdata;

    bavg_ram #(
        .WIDTH (SUMS_W),
        .DEPTH (MAX_BLOCK_COLS)
    ) u_sum_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [MAX_BLOCK_COLS-1:0] ent_vld_reg;

    // ------------------------------------------------------------------
    // Stage 1: add the pixel to the block column sums and write back.
    // A pixel that follows one in the same block column right away takes
    // the sums from the forwarding register, since its RAM read happened
    // in the same cycle as the earlier write.
    // ------------------------------------------------------------------
    logic              s1_vld_reg;
    logic [BCOL_W-1:0] s1_bcol_reg;
    logic [BROW_W-1:0] s1_brow_reg;
    logic              s1_emit_reg;
    logic [23:0]       s1_px_reg;
    logic              s1_hit_reg;
    logic              fwd_reg;
    sums_t             fwd_sum_reg;

    logic              s1_adv;
    sums_t             s1_old;
    sums_t             s1_new;
    logic [3:0]        s1_shamt;
    logic [SUM_W-1:0]  sh_r;
    logic [SUM_W-1:0]  sh_g;
    logic [SUM_W-1:0]  sh_b;

    logic              s2_vld_reg;
    logic              s2_adv;

    always_comb
    begin
        s1_adv  = s1_vld_reg && (!s1_emit_reg || !s2_vld_reg || s2_adv);
        load_s1 = !s1_vld_reg || s1_adv;
        in_stall = !load_s1;
        in_acc  = in_valid && !in_stall;

        ram_re    = in_acc && in_range;
        ram_raddr = bcol_full[BCOL_W-1:0];

        if (fwd_reg)
        begin
            s1_old = fwd_sum_reg;
        end
        else if (s1_hit_reg)
        begin
            s1_old = ram_rdata;
        end
        else
        begin
            s1_old = '0;
        end

        s1_new.red   = s1_old.red   + SUM_W'(s1_px_reg[23:16]);
        s1_new.green = s1_old.green + SUM_W'(s1_px_reg[15:8]);
        s1_new.blue  = s1_old.blue  + SUM_W'(s1_px_reg[7:0]);

        s1_shamt = {lg_eff, 1'b0};
        sh_r = s1_new.red   >> s1_shamt;
        sh_g = s1_new.green >> s1_shamt;
        sh_b = s1_new.blue  >> s1_shamt;

        ram_we    = s1_adv;
        ram_waddr = s1_bcol_reg;
        ram_wdata = s1_emit_reg ? '0 : s1_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            fwd_reg     <= 1'b0;
            ent_vld_reg <= '0;
        end
        else
        begin
            if (ram_we)
            begin
                ent_vld_reg[ram_waddr] <= 1'b1;
            end
            if (load_s1)
            begin
                s1_vld_reg <= in_acc && in_range;
                fwd_reg    <= in_acc && in_range && s1_adv &&
                              (s1_bcol_reg == bcol_full[BCOL_W-1:0]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_s1)
        begin
            s1_bcol_reg <= bcol_full[BCOL_W-1:0];
            s1_brow_reg <= brow_full[BROW_W-1:0];
            s1_emit_reg <= blk_done;
            s1_px_reg   <= pixel_rgb;
            s1_hit_reg  <= ent_vld_reg[bcol_full[BCOL_W-1:0]];
            fwd_sum_reg <= ram_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: averages of a finished block and the gray level.
    // ------------------------------------------------------------------
    logic [BCOL_W-1:0] s2_bcol_reg;
    logic [BROW_W-1:0] s2_brow_reg;
    logic [7:0]        s2_r_reg;
    logic [7:0]        s2_g_reg;
    logic [7:0]        s2_b_reg;
    logic              load_s2;
    logic [9:0]        s2_sum;
    logic [19:0]       s2_prod;
    logic [3:0]        s2_gray;

    logic              out_vld_reg;
    logic              load_out;

    always_comb
    begin
        load_out = !out_vld_reg || !out_stall;
        s2_adv   = s2_vld_reg && load_out;
        load_s2  = !s2_vld_reg || s2_adv;
        s2_sum   = 10'(s2_r_reg) + 10'(s2_g_reg) + 10'(s2_b_reg);
        s2_prod  = 20'(s2_sum) * 20'(DIV3_RECIP);
        // The quotient sits at bits DIV3_SHIFT and up; its top four bits remain.
        s2_gray  = s2_prod[DIV3_SHIFT+7:DIV3_SHIFT+4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else if (load_s2)
        begin
            s2_vld_reg <= s1_adv && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_s2)
        begin
            s2_bcol_reg <= s1_bcol_reg;
            s2_brow_reg <= s1_brow_reg;
            s2_r_reg    <= sh_r[7:0];
            s2_g_reg    <= sh_g[7:0];
            s2_b_reg    <= sh_b[7:0];
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            block_col <= s2_bcol_reg;
            block_row <= s2_brow_reg;
            if (paint_reg)
            begin
                avg_color  <= {s2_r_reg, s2_g_reg, s2_b_reg & COLOR_KEEP_MASK};
                gray_level <= '0;
            end
            else
            begin
                avg_color  <= '0;
                gray_level <= s2_gray;
            end
        end
    end

    assign out_valid = out_vld_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_stall_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_vld_reg)
        else $error("input stalled with an empty add stage");

    a_fwd_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> s1_vld_reg)
        else $error("forwarding flag set without an item in the add stage");

    a_emit_reaches_s2: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_emit_reg) |=> s2_vld_reg)
        else $error("finished block lost between add stage and gray stage");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && s1_emit_reg) |-> (ram_wdata == '0))
        else $error("finished block sums not cleared on write-back");

endmodule
